// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
// Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ----- sv/pl0sm_pkg.sv -----
`timescale 1ns / 1ps

package pl0sm_pkg;

	localparam int STACK_DEPTH_DEF = 2048;
	localparam int REG_MARGIN_DEF  = 20;
	localparam int LEVELS_DEF      = 8;
	localparam int CODE_SIZE       = 256;
	localparam int PC_W            = 8;
	localparam int WORD_W          = 32;

	localparam logic [3:0] MODE_LIT = 4'd0;
	localparam logic [3:0] MODE_OPR = 4'd1;
	localparam logic [3:0] MODE_LOD = 4'd2;
	localparam logic [3:0] MODE_STO = 4'd3;
	localparam logic [3:0] MODE_CAL = 4'd4;
	localparam logic [3:0] MODE_RET = 4'd5;
	localparam logic [3:0] MODE_ICT = 4'd6;
	localparam logic [3:0] MODE_JMP = 4'd7;
	localparam logic [3:0] MODE_JPC = 4'd8;

	localparam logic [3:0] ALU_NEG  = 4'd0;
	localparam logic [3:0] ALU_ADD  = 4'd1;
	localparam logic [3:0] ALU_SUB  = 4'd2;
	localparam logic [3:0] ALU_MUL  = 4'd3;
	localparam logic [3:0] ALU_DIV  = 4'd4;
	localparam logic [3:0] ALU_ODD  = 4'd5;
	localparam logic [3:0] ALU_EQ   = 4'd6;
	localparam logic [3:0] ALU_LS   = 4'd7;
	localparam logic [3:0] ALU_GR   = 4'd8;
	localparam logic [3:0] ALU_NEQ  = 4'd9;
	localparam logic [3:0] ALU_LSEQ = 4'd10;
	localparam logic [3:0] ALU_GREQ = 4'd11;
	localparam logic [3:0] ALU_WRT  = 4'd12;
	localparam logic [3:0] ALU_WRL  = 4'd13;

	localparam logic [2:0] FAULT_NONE  = 3'd0;
	localparam logic [2:0] FAULT_OVF   = 3'd1;
	localparam logic [2:0] FAULT_DIV0  = 3'd2;
	localparam logic [2:0] FAULT_RANGE = 3'd3;
	localparam logic [2:0] FAULT_LEVEL = 3'd4;

	localparam logic [1:0] PK_NONE = 2'd0;
	localparam logic [1:0] PK_NUM  = 2'd1;
	localparam logic [1:0] PK_NL   = 2'd2;

	typedef struct packed {
		logic [3:0]         mode;
		logic [3:0]         alu_op;
		logic [2:0]         level;
		logic signed [31:0] operand;
	} instr_t;

	typedef struct packed {
		logic [PC_W-1:0]    next_pc;
		logic               halted;
		logic [1:0]         print_kind;
		logic signed [31:0] print_value;
		logic [2:0]         fault;
	} result_t;

endpackage

// ----- sv/pl0sm_div.sv -----
`timescale 1ns / 1ps

module pl0sm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pl0sm_pkg::WORD_W-1:0]  dividend,
	input  logic [pl0sm_pkg::WORD_W-1:0]  divisor,
	output logic                          done,
	output logic [pl0sm_pkg::WORD_W-1:0]  quotient
);

	localparam int W  = pl0sm_pkg::WORD_W;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  num_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  rem_q;
	logic          neg_q;
	logic [W:0]    trial;
	logic          ge;

	assign trial    = {rem_q, num_q[W-1]} - {1'b0, den_q};
	assign ge       = !trial[W];
	assign done     = done_q;
	assign quotient = neg_q ? (W'(0) - num_q) : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle on magnitudes; sign fixed at the end
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[W-1] ? (W'(0) - dividend) : dividend;
			den_q <= divisor[W-1] ? (W'(0) - divisor) : divisor;
			rem_q <= '0;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[W-1:0] : {rem_q[W-2:0], num_q[W-1]};
			num_q <= {num_q[W-2:0], ge};
		end
	end

endmodule

// ----- sv/pl0_stack_machine_step_core.sv -----
// Steps: decode, a read and read-wait pair per stack word read, calc, the serial divider
// for div, a write per stack word written, fin, result; a fault skips to fin.
// Takes one instruction at a time: instr_stall stays high from acceptance until the result
// is taken, as the stack memory, the shared ALU and the serial divider serve one instruction.
// Reset: asynchronous, active low; a clearing pass then zeroes the whole stack memory,
// and no instruction is taken until it ends.
`timescale 1ns / 1ps

module pl0_stack_machine_step_core #(
	parameter int STACK_DEPTH = pl0sm_pkg::STACK_DEPTH_DEF,
	parameter int REG_MARGIN  = pl0sm_pkg::REG_MARGIN_DEF,
	parameter int LEVELS      = pl0sm_pkg::LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               instr_valid,
	output logic               instr_stall,
	input  pl0sm_pkg::instr_t  instr,
	output logic               result_valid,
	input  logic               result_stall,
	output pl0sm_pkg::result_t result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int TW = $clog2(STACK_DEPTH + 1);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int LN = 1 << LW;
	localparam int XW = 34;
	localparam int PW = pl0sm_pkg::PC_W;

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b0000000001,
		ST_IDLE   = 10'b0000000010,
		ST_DECODE = 10'b0000000100,
		ST_READ   = 10'b0000001000,
		ST_READW  = 10'b0000010000,
		ST_CALC   = 10'b0000100000,
		ST_DIV    = 10'b0001000000,
		ST_WRITE  = 10'b0010000000,
		ST_FIN    = 10'b0100000000,
		ST_RESULT = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [PW-1:0]     pc_q;
	logic [TW-1:0]     top_q;
	logic              stop_q;
	logic [AW-1:0]     disp_q [LN];
	logic [1:0]        rd_q;
	logic              wr_q;

	pl0sm_pkg::instr_t  ins_q;
	pl0sm_pkg::result_t res_q;
	logic [31:0]       mem [STACK_DEPTH];
	logic [31:0]       rdata_q;
	logic [31:0]       d_q [3];
	logic [1:0]        nrd_q;
	logic [1:0]        nwr_q;
	logic [AW-1:0]     wa_q [2];
	logic [31:0]       wd_q [2];
	logic [TW-1:0]     ntop_q;
	logic              dwe_q;
	logic [LW-1:0]     didx_q;
	logic [AW-1:0]     dval_q;
	logic [PW-1:0]     npc_q;
	logic [1:0]        pk_q;
	logic [31:0]       pv_q;
	logic [2:0]        fault_q;

	logic              lvl_ok, cal_ok, top_full, top_lt1, top_lt2, cal_fit, base_fit;
	logic [LW-1:0]     lvl_idx, lvl1_idx;
	logic [AW-1:0]     base, topa, topm1, topm2, topp1, rd_addr;
	logic [XW-1:0]     opx, fa, ra, ia;
	logic              fa_ok, ra_ok, ia_neg, ia_big;
	logic [PW-1:0]     pc_seq, target;
	logic              is_un, is_bin;
	logic [31:0]       x, y, alu_r;
	logic [2:0]        dec_fault;
	logic [1:0]        dec_nrd;

	logic [2:0]        c_fault;
	logic [1:0]        c_nwr;
	logic [AW-1:0]     c_wa0, c_wa1;
	logic [31:0]       c_wd0, c_wd1;
	logic [TW-1:0]     c_ntop;
	logic              c_dwe;
	logic [LW-1:0]     c_didx;
	logic [AW-1:0]     c_dval;
	logic [PW-1:0]     c_npc;
	logic [1:0]        c_pk;
	logic [31:0]       c_pv;
	logic              c_div;

	logic              div_start, div_done;
	logic [31:0]       div_quo;

	assign instr_stall  = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_RESULT);
	assign result       = res_q;

	// operand decode shared by the check and execute steps
	assign lvl_ok   = (32'(ins_q.level) < 32'(LEVELS));
	assign cal_ok   = (32'(ins_q.level) + 32'd1 < 32'(LEVELS));
	assign lvl_idx  = LW'(ins_q.level);
	assign lvl1_idx = LW'(32'(ins_q.level) + 32'd1);
	assign base     = disp_q[lvl_idx];
	assign opx      = {{(XW - 32){ins_q.operand[31]}}, ins_q.operand};
	assign fa       = XW'(base) + opx;
	assign ra       = XW'(base) - opx;
	assign ia       = XW'(top_q) + opx;
	assign fa_ok    = !fa[XW-1] && (fa < XW'(STACK_DEPTH));
	assign ra_ok    = !ra[XW-1] && (ra < XW'(STACK_DEPTH));
	assign ia_neg   = ia[XW-1];
	assign ia_big   = !ia[XW-1] && (ia >= XW'(STACK_DEPTH - REG_MARGIN));
	assign top_full = (32'(top_q) >= 32'(STACK_DEPTH));
	assign top_lt1  = (top_q == '0);
	assign top_lt2  = (32'(top_q) < 32'd2);
	assign cal_fit  = (32'(top_q) + 32'd1 < 32'(STACK_DEPTH));
	assign base_fit = (32'(base) + 32'd1 < 32'(STACK_DEPTH));
	assign topa     = AW'(top_q);
	assign topm1    = AW'(top_q - TW'(1));
	assign topm2    = AW'(top_q - TW'(2));
	assign topp1    = AW'(top_q + TW'(1));
	assign pc_seq   = pc_q + PW'(1);
	assign target   = ins_q.operand[PW-1:0];
	assign is_un    = (ins_q.alu_op == pl0sm_pkg::ALU_NEG) ||
	                  (ins_q.alu_op == pl0sm_pkg::ALU_ODD) ||
	                  (ins_q.alu_op == pl0sm_pkg::ALU_WRT);
	assign is_bin   = (ins_q.alu_op >= pl0sm_pkg::ALU_ADD) &&
	                  (ins_q.alu_op <= pl0sm_pkg::ALU_GREQ) &&
	                  (ins_q.alu_op != pl0sm_pkg::ALU_ODD);
	assign x        = d_q[0];
	assign y        = d_q[1];

	always_comb begin
		dec_fault = pl0sm_pkg::FAULT_NONE;
		dec_nrd   = 2'd0;
		case (ins_q.mode)
			pl0sm_pkg::MODE_LIT: begin
				if (top_full) dec_fault = pl0sm_pkg::FAULT_OVF;
			end
			pl0sm_pkg::MODE_OPR: begin
				if (is_un) begin
					if (top_lt1) dec_fault = pl0sm_pkg::FAULT_RANGE;
					else dec_nrd = 2'd1;
				end else if (is_bin) begin
					if (top_lt2) dec_fault = pl0sm_pkg::FAULT_RANGE;
					else dec_nrd = 2'd2;
				end
			end
			pl0sm_pkg::MODE_LOD: begin
				if (!lvl_ok) dec_fault = pl0sm_pkg::FAULT_LEVEL;
				else if (!fa_ok) dec_fault = pl0sm_pkg::FAULT_RANGE;
				else if (top_full) dec_fault = pl0sm_pkg::FAULT_OVF;
				else dec_nrd = 2'd1;
			end
			pl0sm_pkg::MODE_STO: begin
				if (!lvl_ok) dec_fault = pl0sm_pkg::FAULT_LEVEL;
				else if (!fa_ok || top_lt1) dec_fault = pl0sm_pkg::FAULT_RANGE;
				else dec_nrd = 2'd1;
			end
			pl0sm_pkg::MODE_CAL: begin
				if (!cal_ok) dec_fault = pl0sm_pkg::FAULT_LEVEL;
				else if (!cal_fit) dec_fault = pl0sm_pkg::FAULT_RANGE;
			end
			pl0sm_pkg::MODE_RET: begin
				if (!lvl_ok) dec_fault = pl0sm_pkg::FAULT_LEVEL;
				else if (top_lt1 || !base_fit || !ra_ok) dec_fault = pl0sm_pkg::FAULT_RANGE;
				else dec_nrd = 2'd3;
			end
			pl0sm_pkg::MODE_ICT: begin
				if (ia_neg) dec_fault = pl0sm_pkg::FAULT_RANGE;
				else if (ia_big) dec_fault = pl0sm_pkg::FAULT_OVF;
			end
			pl0sm_pkg::MODE_JPC: begin
				if (top_lt1) dec_fault = pl0sm_pkg::FAULT_RANGE;
				else dec_nrd = 2'd1;
			end
			default: ;
		endcase
	end

	// ret reads link, then value, then return address
	always_comb begin
		case (ins_q.mode)
			pl0sm_pkg::MODE_OPR: rd_addr = (is_bin && rd_q == 2'd0) ? topm2 : topm1;
			pl0sm_pkg::MODE_LOD: rd_addr = AW'(fa);
			pl0sm_pkg::MODE_RET: begin
				if (rd_q == 2'd0) rd_addr = base;
				else if (rd_q == 2'd1) rd_addr = topm1;
				else rd_addr = AW'(XW'(base) + XW'(1));
			end
			default: rd_addr = topm1;
		endcase
	end

	// shared ALU
	always_comb begin
		case (ins_q.alu_op)
			pl0sm_pkg::ALU_NEG:  alu_r = 32'd0 - x;
			pl0sm_pkg::ALU_ADD:  alu_r = x + y;
			pl0sm_pkg::ALU_SUB:  alu_r = x - y;
			pl0sm_pkg::ALU_MUL:  alu_r = x * y;
			pl0sm_pkg::ALU_ODD:  alu_r = {31'd0, x[0]};
			pl0sm_pkg::ALU_EQ:   alu_r = {31'd0, x == y};
			pl0sm_pkg::ALU_LS:   alu_r = {31'd0, $signed(x) < $signed(y)};
			pl0sm_pkg::ALU_GR:   alu_r = {31'd0, $signed(x) > $signed(y)};
			pl0sm_pkg::ALU_NEQ:  alu_r = {31'd0, x != y};
			pl0sm_pkg::ALU_LSEQ: alu_r = {31'd0, $signed(x) <= $signed(y)};
			pl0sm_pkg::ALU_GREQ: alu_r = {31'd0, $signed(x) >= $signed(y)};
			default:             alu_r = '0;
		endcase
	end

	always_comb begin
		c_fault = pl0sm_pkg::FAULT_NONE;
		c_nwr   = 2'd0;
		c_wa0   = topa;
		c_wd0   = alu_r;
		c_wa1   = topp1;
		c_wd1   = 32'(pc_seq);
		c_ntop  = top_q;
		c_dwe   = 1'b0;
		c_didx  = lvl_idx;
		c_dval  = topa;
		c_npc   = pc_seq;
		c_pk    = pl0sm_pkg::PK_NONE;
		c_pv    = '0;
		c_div   = 1'b0;
		case (ins_q.mode)
			pl0sm_pkg::MODE_LIT: begin
				c_nwr  = 2'd1;
				c_wd0  = ins_q.operand;
				c_ntop = top_q + TW'(1);
			end
			pl0sm_pkg::MODE_OPR: begin
				if (ins_q.alu_op == pl0sm_pkg::ALU_WRL) begin
					c_pk = pl0sm_pkg::PK_NL;
				end else if (ins_q.alu_op == pl0sm_pkg::ALU_WRT) begin
					c_pk   = pl0sm_pkg::PK_NUM;
					c_pv   = x;
					c_ntop = top_q - TW'(1);
				end else if (is_un) begin
					c_nwr = 2'd1;
					c_wa0 = topm1;
				end else if (is_bin) begin
					c_nwr  = 2'd1;
					c_wa0  = topm2;
					c_ntop = top_q - TW'(1);
					if (ins_q.alu_op == pl0sm_pkg::ALU_DIV) begin
						if (y == '0) c_fault = pl0sm_pkg::FAULT_DIV0;
						else c_div = 1'b1;
					end
				end
			end
			pl0sm_pkg::MODE_LOD: begin
				c_nwr  = 2'd1;
				c_wd0  = x;
				c_ntop = top_q + TW'(1);
			end
			pl0sm_pkg::MODE_STO: begin
				c_nwr  = 2'd1;
				c_wa0  = AW'(fa);
				c_wd0  = x;
				c_ntop = top_q - TW'(1);
			end
			pl0sm_pkg::MODE_CAL: begin
				c_nwr  = 2'd2;
				c_wd0  = 32'(disp_q[lvl1_idx]);
				c_dwe  = 1'b1;
				c_didx = lvl1_idx;
				c_npc  = target;
			end
			pl0sm_pkg::MODE_RET: begin
				if (x >= 32'(STACK_DEPTH)) begin
					c_fault = pl0sm_pkg::FAULT_RANGE;
				end else begin
					c_nwr  = 2'd1;
					c_wa0  = AW'(ra);
					c_wd0  = d_q[1];
					c_dwe  = 1'b1;
					c_dval = AW'(x);
					c_npc  = d_q[2][PW-1:0];
					c_ntop = TW'(ra) + TW'(1);
				end
			end
			pl0sm_pkg::MODE_ICT: c_ntop = TW'(ia);
			pl0sm_pkg::MODE_JMP: c_npc = target;
			pl0sm_pkg::MODE_JPC: begin
				c_ntop = top_q - TW'(1);
				if (x == '0) c_npc = target;
			end
			default: ;
		endcase
	end

	assign div_start = (state_q == ST_CALC) && c_div;

	pl0sm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (x),
		.divisor  (y),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pc_q    <= '0;
			top_q   <= '0;
			stop_q  <= 1'b0;
			rd_q    <= '0;
			wr_q    <= 1'b0;
			for (int i = 0; i < LN; i++) disp_q[i] <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STACK_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (instr_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					rd_q <= '0;
					if (stop_q || dec_fault != pl0sm_pkg::FAULT_NONE) begin
						state_q <= stop_q ? ST_RESULT : ST_FIN;
					end else if (dec_nrd == 2'd0) begin
						state_q <= ST_CALC;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_READW;
				ST_READW: begin
					if (rd_q == nrd_q - 2'd1) begin
						state_q <= ST_CALC;
					end else begin
						rd_q    <= rd_q + 2'd1;
						state_q <= ST_READ;
					end
				end
				ST_CALC: begin
					wr_q <= 1'b0;
					if (c_fault != pl0sm_pkg::FAULT_NONE || c_nwr == 2'd0) state_q <= ST_FIN;
					else if (c_div) state_q <= ST_DIV;
					else state_q <= ST_WRITE;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if ({1'b0, wr_q} == nwr_q - 2'd1) state_q <= ST_FIN;
					else wr_q <= 1'b1;
				end
				ST_FIN: begin
					state_q <= ST_RESULT;
					if (fault_q != pl0sm_pkg::FAULT_NONE) begin
						pc_q   <= pc_seq;
						stop_q <= 1'b1;
					end else begin
						pc_q   <= npc_q;
						top_q  <= ntop_q;
						stop_q <= (npc_q == '0);
						if (dwe_q) disp_q[didx_q] <= dval_q;
					end
				end
				ST_RESULT: begin
					if (!result_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem[clr_q] <= '0;
		else if (state_q == ST_WRITE) mem[wa_q[wr_q]] <= wd_q[wr_q];
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (instr_valid) ins_q <= instr;
			end
			ST_DECODE: begin
				nrd_q   <= dec_nrd;
				fault_q <= dec_fault;
				res_q   <= '{next_pc: pc_q, halted: 1'b1, print_kind: pl0sm_pkg::PK_NONE,
				             print_value: '0, fault: pl0sm_pkg::FAULT_NONE};
			end
			ST_READW: d_q[rd_q] <= rdata_q;
			ST_CALC: begin
				fault_q <= c_fault;
				nwr_q   <= c_nwr;
				wa_q[0] <= c_wa0;
				wd_q[0] <= c_wd0;
				wa_q[1] <= c_wa1;
				wd_q[1] <= c_wd1;
				ntop_q  <= c_ntop;
				dwe_q   <= c_dwe;
				didx_q  <= c_didx;
				dval_q  <= c_dval;
				npc_q   <= c_npc;
				pk_q    <= c_pk;
				pv_q    <= c_pv;
			end
			ST_DIV: begin
				if (div_done) wd_q[0] <= div_quo;
			end
			ST_FIN: begin
				if (fault_q != pl0sm_pkg::FAULT_NONE) begin
					res_q <= '{next_pc: pc_seq, halted: 1'b1, print_kind: pl0sm_pkg::PK_NONE,
					           print_value: '0, fault: fault_q};
				end else begin
					res_q <= '{next_pc: npc_q, halted: (npc_q == '0), print_kind: pk_q,
					           print_value: $signed(pv_q), fault: pl0sm_pkg::FAULT_NONE};
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/pl0sm_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pl0sm_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               instr_valid,
	input logic               instr_stall,
	input logic               result_valid,
	input logic               result_stall,
	input pl0sm_pkg::result_t result
);

	`ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(result))
	`ASSERT_NOW(a_busy_res, result_valid, instr_stall)
	`ASSERT_NEXT(a_no_early, instr_valid && !instr_stall, !result_valid)
	`ASSERT_NOW(a_fault_halt, result_valid && result.fault != pl0sm_pkg::FAULT_NONE, result.halted && result.print_kind == pl0sm_pkg::PK_NONE)

endmodule

bind pl0_stack_machine_step_core pl0sm_chk u_chk (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import pl0sm_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM       = 920;

	// Step predictor for the p-code core, with its own copy of the machine state.
	class step_scoreboard;
		logic [31:0] stk [STACK_DEPTH_DEF];
		int unsigned disp [LEVELS_DEF];
		int unsigned pc, top;
		bit stopped;
		result_t expected_q [$];
		int errors;

		function new();
			foreach (stk[i]) stk[i] = '0;
			foreach (disp[i]) disp[i] = 0;
			pc = 0;
			top = 0;
			stopped = 0;
			errors = 0;
		endfunction

		// Execute one instruction; state changes only when commit is set.
		function result_t step(instr_t it, bit commit);
			result_t r;
			int unsigned npc, nt, need, base, link;
			logic [1:0] pk;
			logic [31:0] pv, raw, x, y, v, tmp;
			logic [2:0] flt;
			longint a, opnd, sx, sy;
			bit halt;
			raw = it.operand;
			opnd = longint'(it.operand);
			pk = PK_NONE;
			pv = '0;
			flt = FAULT_NONE;
			halt = 0;
			nt = top;
			if (stopped) begin
				r.next_pc = pc[PC_W-1:0];
				r.halted = 1'b1;
				r.print_kind = PK_NONE;
				r.print_value = '0;
				r.fault = FAULT_NONE;
				return r;
			end
			npc = (pc + 1) % CODE_SIZE;
			case (it.mode)
				MODE_LIT: begin
					if (top >= STACK_DEPTH_DEF) flt = FAULT_OVF;
					else begin
						if (commit) stk[top] = raw;
						nt = top + 1;
					end
				end
				MODE_OPR: begin
					need = (it.alu_op == ALU_NEG || it.alu_op == ALU_ODD || it.alu_op == ALU_WRT) ? 1 :
						(it.alu_op <= ALU_GREQ ? 2 : 0);
					if (it.alu_op > ALU_WRL) begin
						// unknown op: advance pc only
					end else if (top < need) flt = FAULT_RANGE;
					else if (it.alu_op == ALU_WRL) pk = PK_NL;
					else if (it.alu_op == ALU_WRT) begin
						pv = stk[top-1];
						pk = PK_NUM;
						nt = top - 1;
					end else if (need == 1) begin
						x = stk[top-1];
						if (commit) stk[top-1] = (it.alu_op == ALU_NEG) ? -x : {31'd0, x[0]};
					end else begin
						x = stk[top-2];
						y = stk[top-1];
						sx = longint'(signed'(x));
						sy = longint'(signed'(y));
						v = '0;
						case (it.alu_op)
							ALU_ADD:  v = x + y;
							ALU_SUB:  v = x - y;
							ALU_MUL:  v = x * y;
							ALU_DIV:  if (y == 0) flt = FAULT_DIV0; else v = 32'(sx / sy);
							ALU_EQ:   v = 32'(x == y);
							ALU_LS:   v = 32'(sx < sy);
							ALU_GR:   v = 32'(sx > sy);
							ALU_NEQ:  v = 32'(x != y);
							ALU_LSEQ: v = 32'(sx <= sy);
							default:  v = 32'(sx >= sy);
						endcase
						if (flt == FAULT_NONE) begin
							nt = top - 1;
							if (commit) stk[top-2] = v;
						end
					end
				end
				MODE_LOD, MODE_STO: begin
					if (it.level >= LEVELS_DEF) flt = FAULT_LEVEL;
					else begin
						a = longint'(disp[it.level]) + opnd;
						if (a < 0 || a >= STACK_DEPTH_DEF) flt = FAULT_RANGE;
						else if (it.mode == MODE_LOD) begin
							if (top >= STACK_DEPTH_DEF) flt = FAULT_OVF;
							else begin
								if (commit) stk[top] = stk[a];
								nt = top + 1;
							end
						end else begin
							if (top < 1) flt = FAULT_RANGE;
							else begin
								if (commit) stk[a] = stk[top-1];
								nt = top - 1;
							end
						end
					end
				end
				MODE_CAL: begin
					if (it.level + 1 >= LEVELS_DEF) flt = FAULT_LEVEL;
					else if (top + 1 >= STACK_DEPTH_DEF) flt = FAULT_RANGE;
					else begin
						if (commit) begin
							stk[top] = disp[it.level+1];
							stk[top+1] = npc;
							disp[it.level+1] = top;
						end
						npc = raw % CODE_SIZE;
					end
				end
				MODE_RET: begin
					if (it.level >= LEVELS_DEF) flt = FAULT_LEVEL;
					else if (top < 1) flt = FAULT_RANGE;
					else begin
						base = disp[it.level];
						if (base + 1 >= STACK_DEPTH_DEF) flt = FAULT_RANGE;
						else begin
							link = stk[base];
							a = longint'(base) - opnd;
							if (link >= STACK_DEPTH_DEF) flt = FAULT_RANGE;
							else if (a < 0 || a >= STACK_DEPTH_DEF) flt = FAULT_RANGE;
							else begin
								tmp = stk[top-1];
								npc = stk[base+1] % CODE_SIZE;
								if (commit) begin
									disp[it.level] = link;
									stk[a] = tmp;
								end
								nt = a + 1;
							end
						end
					end
				end
				MODE_ICT: begin
					a = longint'(top) + opnd;
					if (a < 0) flt = FAULT_RANGE;
					else if (a >= STACK_DEPTH_DEF - REG_MARGIN_DEF) flt = FAULT_OVF;
					else nt = a;
				end
				MODE_JMP: npc = raw % CODE_SIZE;
				MODE_JPC: begin
					if (top < 1) flt = FAULT_RANGE;
					else begin
						nt = top - 1;
						if (stk[top-1] == 0) npc = raw % CODE_SIZE;
					end
				end
				default: ;
			endcase
			if (flt != FAULT_NONE) begin
				npc = (pc + 1) % CODE_SIZE;
				pk = PK_NONE;
				pv = '0;
				halt = 1;
				nt = top;
			end else if (npc == 0) halt = 1;
			if (commit) begin
				pc = npc;
				top = nt;
				if (halt) stopped = 1;
			end
			r.next_pc = npc[PC_W-1:0];
			r.halted = halt;
			r.print_kind = pk;
			r.print_value = pv;
			r.fault = flt;
			return r;
		endfunction

		function void note_instr(instr_t it);
			expected_q.push_back(step(it, 1));
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t e;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			e = expected_q.pop_front();
			if (got.next_pc !== e.next_pc)
				report($sformatf("next_pc %0d, want %0d", got.next_pc, e.next_pc));
			if (got.halted !== e.halted)
				report($sformatf("halted %0b, want %0b", got.halted, e.halted));
			if (got.print_kind !== e.print_kind)
				report($sformatf("print_kind %0d, want %0d", got.print_kind, e.print_kind));
			if (got.print_value !== e.print_value)
				report($sformatf("print_value %0d, want %0d", got.print_value, e.print_value));
			if (got.fault !== e.fault)
				report($sformatf("fault %0d, want %0d", got.fault, e.fault));
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    instr_valid = 1'b0;
	logic    instr_stall;
	instr_t  instr = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	step_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	pl0_stack_machine_step_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr       (instr),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	// Result side: long hold-off when requested, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((instr_valid && !instr_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task send(instr_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr_valid <= 1'b1;
		instr <= it;
		@(posedge clk);
		while (instr_stall) @(posedge clk);
		sb.note_instr(it);
	endtask

	// Send only when the beat keeps the machine running.
	task send_safe(instr_t it);
		result_t p;
		p = sb.step(it, 0);
		if (!p.halted) send(it);
	endtask

	function instr_t mk(logic [3:0] m, logic [3:0] op, logic [2:0] lv, logic [31:0] opnd);
		instr_t it;
		it.mode = m;
		it.alu_op = op;
		it.level = lv;
		it.operand = opnd;
		return it;
	endfunction

	function instr_t pick();
		instr_t c;
		result_t p;
		int w;
		for (int k = 0; k < 30; k++) begin
			w = $urandom_range(0, 99);
			c.alu_op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
				: 4'($urandom_range(0, 13));
			c.level = 3'($urandom_range(0, 7));
			if (w < 25) begin
				c.mode = MODE_LIT;
				c.operand = ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 20)) - 10;
			end else if (w < 55) begin
				c.mode = MODE_OPR;
				c.operand = $urandom;
			end else if (w < 70) begin
				c.mode = (w < 63) ? MODE_LOD : MODE_STO;
				c.operand = 32'($urandom_range(0, sb.top + 1)) - 32'(sb.disp[c.level]);
			end else if (w < 75) begin
				c.mode = MODE_CAL;
				c.operand = $urandom;
			end else if (w < 80) begin
				c.mode = MODE_RET;
				c.operand = 32'($urandom_range(0, 3));
			end else if (w < 85) begin
				c.mode = MODE_ICT;
				c.operand = ($urandom_range(0, 15) == 0) ? $urandom
					: 32'($urandom_range(0, 8)) - 4;
			end else if (w < 96) begin
				c.mode = (w < 90) ? MODE_JMP : MODE_JPC;
				c.operand = $urandom;
			end else begin
				c.mode = 4'($urandom_range(9, 15));
				c.operand = $urandom;
			end
			p = sb.step(c, 0);
			if (!p.halted) return c;
		end
		return mk(MODE_JMP, '0, '0, {24'($urandom), 8'd0} | 32'($urandom_range(1, 255)));
	endfunction

	task wait_drained();
		instr_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: operand extremes, every ALU op, division corners, frames.
		send_safe(mk(MODE_LIT, '0, '0, 32'h7fffffff));
		send_safe(mk(MODE_LIT, '0, '0, 32'h80000000));
		send_safe(mk(MODE_OPR, ALU_SUB, '0, '0));
		send_safe(mk(MODE_LIT, '0, '0, 32'h80000000));
		send_safe(mk(MODE_LIT, '0, '0, 32'hffffffff));
		send_safe(mk(MODE_OPR, ALU_DIV, '0, '0));
		send_safe(mk(MODE_LIT, '0, '0, -32'sd7));
		send_safe(mk(MODE_LIT, '0, '0, 32'd2));
		send_safe(mk(MODE_OPR, ALU_DIV, '0, '0));
		send_safe(mk(MODE_OPR, ALU_MUL, '0, '0));
		send_safe(mk(MODE_OPR, ALU_NEG, '0, '0));
		send_safe(mk(MODE_OPR, ALU_ODD, '0, '0));
		for (int i = 0; i < 7; i++) send_safe(mk(MODE_LIT, '0, '0, 32'(i) - 3));
		for (int op = ALU_EQ; op <= ALU_GREQ; op++) send_safe(mk(MODE_OPR, 4'(op), '0, '0));
		send_safe(mk(MODE_OPR, ALU_ADD, '0, '0));
		send_safe(mk(MODE_OPR, ALU_WRT, '0, '0));
		send_safe(mk(MODE_OPR, ALU_WRL, '0, '0));
		send_safe(mk(MODE_OPR, 4'd15, '0, '0));
		send_safe(mk(MODE_LOD, '0, 3'd7, '0));
		send_safe(mk(MODE_STO, '0, '0, '0));
		send_safe(mk(4'd15, 4'd15, 3'd7, 32'hffffffff));
		send_safe(mk(MODE_CAL, '0, '0, 32'h1234_5628));
		send_safe(mk(MODE_ICT, '0, '0, 32'd3));
		send_safe(mk(MODE_LIT, '0, '0, 32'd0));
		send_safe(mk(MODE_RET, '0, 3'd1, '0));
		send_safe(mk(MODE_JPC, '0, '0, 32'd77));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  hold_left = 300; end
				1: begin idle_pct = 66; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 66; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				send(pick());
			end
			if (ph == 1) wait_drained();
		end

		// Finish with one fault, then beats against the stopped machine.
		case ($urandom_range(0, 3))
			0: send(mk(MODE_CAL, '0, 3'd7, '0));
			1: send(mk(MODE_LOD, '0, '0, 32'h80000000));
			2: begin
				send_safe(mk(MODE_LIT, '0, '0, 32'd5));
				send_safe(mk(MODE_LIT, '0, '0, 32'd0));
				send(mk(MODE_OPR, ALU_DIV, '0, '0));
			end
			default: send(mk(MODE_ICT, '0, '0, 32'd2047));
		endcase
		for (int i = 0; i < 3; i++) send(mk(MODE_LIT, '0, '0, $urandom));

		wait_drained();
		stall_pct = 0;
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
